// ----- hw/rtl/round_robin_slice_scheduler_assert.svh -----
// assertion macros used by the scheduler back end
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RRSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication, checked outside reset
`define RRSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ----- hw/rtl/rrss_pkg.sv -----
// shared types and constants of the round-robin slice scheduler
`timescale 1ns / 1ps

package rrss_pkg;

    localparam int NUM_SLOTS_DEFAULT = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int FUNC_W = 3;
    localparam int ID_W = 4;
    localparam int PRIV_W = 4;
    localparam int STATUS_W = 2;
    localparam int SLICE_CFG_W = 6;
    localparam int SLICE_W = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_BLOCK = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNBLOCK = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ENTER = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_EXIT = 3'd5;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_PENDING = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SLICE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_SLICE = 1'd1;

    localparam logic [SLICE_CFG_W-1:0] KERNEL_SLICE_RESET = 6'd30;
    localparam logic [SLICE_CFG_W-1:0] USER_SLICE_RESET = 6'd10;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   task_id;
        logic              id_bad;
        logic              is_user;
    } t_item;

endpackage

// ----- hw/rtl/round_robin_slice_scheduler.sv -----
// top level of the round-robin time-slice task scheduler
`timescale 1ns / 1ps

// usage
//   command channel: drive i_func, i_task_id, i_privilege with start high; the
//   transaction is taken at a rising edge where start is high and busy is low
//   result channel: o_done is high for one cycle with o_status_code, o_new_id,
//   o_running_id, o_running_valid and o_context_reload; every command yields
//   exactly one result, in command order
//   config port: i_cfg_we, i_cfg_idx (0 kernel slice, 1 user slice), i_cfg_data,
//   written at the clock edge, only while no command is in flight
//   the command is stored in the queue at the accepting edge; the back end
//   executes it from the queue front and registers the result that drives o_done
//   throughput: one command per cycle; the back end finishes each command,
//   including the rotating ready-slot search, as soon as it reaches the queue
//   front, so the two-entry command queue never fills and busy stays low in practice
//   reset: synchronous, active low; clears the task table, running slot,
//   slice counter and queue, and loads slice defaults 30 and 10
//   results cannot be held off by the receiver; none are buffered beyond the
//   strobe cycle
module round_robin_slice_scheduler #(
    parameter int NUM_SLOTS = rrss_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rrss_pkg::FUNC_W-1:0]         i_func,
    input  logic [rrss_pkg::ID_W-1:0]           i_task_id,
    input  logic signed [rrss_pkg::PRIV_W-1:0]  i_privilege,
    input  logic                                i_cfg_we,
    input  logic [rrss_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rrss_pkg::SLICE_CFG_W-1:0]    i_cfg_data,
    output logic                                o_done,
    output logic [rrss_pkg::STATUS_W-1:0]       o_status_code,
    output logic [rrss_pkg::ID_W-1:0]           o_new_id,
    output logic [rrss_pkg::ID_W-1:0]           o_running_id,
    output logic                                o_running_valid,
    output logic                                o_context_reload
);

    logic            q_full;
    logic            q_valid;
    logic            push;
    logic            pop;
    rrss_pkg::t_item front_item;
    rrss_pkg::t_item back_item;

    assign busy = q_full;

    rrss_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .start(start),
        .i_queue_full(q_full),
        .i_func(i_func),
        .i_task_id(i_task_id),
        .i_privilege(i_privilege),
        .o_push(push),
        .o_item(front_item)
    );

    rrss_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_item(front_item),
        .i_pop(pop),
        .o_valid(q_valid),
        .o_full(q_full),
        .o_item(back_item)
    );

    rrss_back #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_item(back_item),
        .o_pop(pop),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_done(o_done),
        .o_status_code(o_status_code),
        .o_new_id(o_new_id),
        .o_running_id(o_running_id),
        .o_running_valid(o_running_valid),
        .o_context_reload(o_context_reload)
    );

endmodule

// ----- hw/rtl/rrss_front.sv -----
// command front end: accepts transactions, range-checks the id, classes the privilege
`timescale 1ns / 1ps

module rrss_front #(
    parameter int NUM_SLOTS = rrss_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                                start,
    input  logic                                i_queue_full,
    input  logic [rrss_pkg::FUNC_W-1:0]         i_func,
    input  logic [rrss_pkg::ID_W-1:0]           i_task_id,
    input  logic signed [rrss_pkg::PRIV_W-1:0]  i_privilege,
    output logic                                o_push,
    output rrss_pkg::t_item                     o_item
);

    logic [31:0] id_wide;

    assign id_wide = {{(32 - rrss_pkg::ID_W){1'b0}}, i_task_id};
    assign o_push = start && !i_queue_full;

    always_comb begin
        o_item.func = i_func;
        o_item.task_id = i_task_id;
        o_item.id_bad = (id_wide >= 32'(NUM_SLOTS));
        // privilege 3 and anything outside 0..3 run as user
        o_item.is_user = i_privilege[3] | i_privilege[2] | (i_privilege[1] & i_privilege[0]);
    end

endmodule

// ----- hw/rtl/rrss_queue.sv -----
// short command queue between the front end and the execution back end
`timescale 1ns / 1ps

module rrss_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rrss_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output rrss_pkg::t_item o_item
);

    localparam int QW = (rrss_pkg::QUEUE_DEPTH > 1) ? $clog2(rrss_pkg::QUEUE_DEPTH) : 1;
    localparam logic [QW-1:0] LAST = QW'(rrss_pkg::QUEUE_DEPTH - 1);
    localparam logic [QW:0] DEPTH_CNT = (QW + 1)'(rrss_pkg::QUEUE_DEPTH);

    rrss_pkg::t_item r_mem [rrss_pkg::QUEUE_DEPTH];
    logic [QW-1:0] r_wr;
    logic [QW-1:0] r_rd;
    logic [QW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full = (r_cnt == DEPTH_CNT);
    assign o_item = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/rrss_back.sv -----
// execution back end: task table, running slot, slice counter and result register
`timescale 1ns / 1ps

`include "round_robin_slice_scheduler_assert.svh"

module rrss_back #(
    parameter int NUM_SLOTS = rrss_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  rrss_pkg::t_item                       i_item,
    output logic                                  o_pop,
    input  logic                                  i_cfg_we,
    input  logic [rrss_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rrss_pkg::SLICE_CFG_W-1:0]      i_cfg_data,
    output logic                                  o_done,
    output logic [rrss_pkg::STATUS_W-1:0]         o_status_code,
    output logic [rrss_pkg::ID_W-1:0]             o_new_id,
    output logic [rrss_pkg::ID_W-1:0]             o_running_id,
    output logic                                  o_running_valid,
    output logic                                  o_context_reload
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [SW:0] N_CNT = (SW + 1)'(NUM_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

    logic [1:0] r_stat [NUM_SLOTS];
    logic [1:0] n_stat [NUM_SLOTS];
    logic [1:0] r_save [NUM_SLOTS];
    logic [1:0] n_save [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_user;
    logic [NUM_SLOTS-1:0] n_user;
    logic [SW-1:0] r_run;
    logic [SW-1:0] n_run;
    logic          r_present;
    logic          n_present;
    logic [rrss_pkg::SLICE_W-1:0] r_slice;
    logic [rrss_pkg::SLICE_W-1:0] n_slice;
    logic [rrss_pkg::SLICE_CFG_W-1:0] r_kernel;
    logic [rrss_pkg::SLICE_CFG_W-1:0] r_usr_slice;

    logic                         r_done;
    logic [rrss_pkg::STATUS_W-1:0] r_status;
    logic [rrss_pkg::STATUS_W-1:0] n_status;
    logic [rrss_pkg::ID_W-1:0]    r_new_id;
    logic [rrss_pkg::ID_W-1:0]    n_new_id;
    logic [rrss_pkg::ID_W-1:0]    r_out_run;
    logic                         r_out_valid;
    logic                         r_reload;
    logic                         n_reload;

    logic [NUM_SLOTS-1:0] ready_v;
    logic [NUM_SLOTS-1:0] empty_v;
    logic [NUM_SLOTS-1:0] search_v;
    logic [2*NUM_SLOTS-1:0] dbl_v;
    logic [NUM_SLOTS-1:0] rot_v;
    logic [SW-1:0] search_start;
    logic [SW:0]   rot_hit;
    logic [SW:0]   empty_hit;
    logic [SW:0]   idx_sum;
    logic [SW-1:0] found_idx;
    logic          found;
    logic [SW-1:0] empty_idx;
    logic [SW+3:0] id_wide;
    logic [SW-1:0] id_slot;
    logic [SW-1:0] run_next;
    logic [SW-1:0] id_next;
    logic [rrss_pkg::SLICE_W-1:0] found_reload;
    logic [rrss_pkg::SLICE_W-1:0] create_reload;
    logic [SW+3:0] new_wide;
    logic [SW+3:0] run_wide;
    logic          bad_id;

    // {found, index} of the lowest set bit
    function automatic logic [SW:0] first_set(input logic [NUM_SLOTS-1:0] vec);
        logic          hit;
        logic [SW-1:0] idx;
        hit = 1'b0;
        idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                hit = 1'b1;
                idx = SW'(i);
            end
        end
        return {hit, idx};
    endfunction

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            ready_v[i] = (r_stat[i] == rrss_pkg::ST_READY);
            empty_v[i] = (r_stat[i] == rrss_pkg::ST_EMPTY);
        end
    end

    assign id_wide = {{SW{1'b0}}, i_item.task_id};
    assign id_slot = id_wide[SW-1:0];
    assign run_next = (r_run == LAST_SLOT) ? '0 : r_run + 1'b1;
    assign id_next = (id_slot == LAST_SLOT) ? '0 : id_slot + 1'b1;
    assign bad_id = i_item.id_bad || empty_v[id_slot];

    // one rotating search shared by tick and block
    always_comb begin
        search_v = ready_v;
        search_start = '0;
        if (i_item.func == rrss_pkg::FUNC_BLOCK) begin
            search_v[id_slot] = 1'b0;
            search_start = id_next;
        end else if (r_present) begin
            search_start = run_next;
        end
    end

    assign dbl_v = {search_v, search_v} >> search_start;
    assign rot_v = dbl_v[NUM_SLOTS-1:0];
    assign rot_hit = first_set(rot_v);
    assign found = rot_hit[SW];
    assign idx_sum = {1'b0, search_start} + {1'b0, rot_hit[SW-1:0]};

    always_comb begin
        if (idx_sum >= N_CNT) begin
            found_idx = SW'(idx_sum - N_CNT);
        end else begin
            found_idx = idx_sum[SW-1:0];
        end
    end

    assign empty_hit = first_set(empty_v);
    assign empty_idx = empty_hit[SW-1:0];
    assign found_reload = {1'b0, r_user[found_idx] ? r_usr_slice : r_kernel};
    assign create_reload = {1'b0, i_item.is_user ? r_usr_slice : r_kernel};

    always_comb begin
        n_stat = r_stat;
        n_save = r_save;
        n_user = r_user;
        n_run = r_run;
        n_present = r_present;
        n_slice = r_slice;
        n_status = rrss_pkg::STATUS_OK;
        n_new_id = '0;
        n_reload = 1'b0;
        new_wide = '0;
        if (i_valid) begin
            case (i_item.func)
                rrss_pkg::FUNC_TICK: begin
                    if (r_present && r_slice != '0) begin
                        n_slice = r_slice - 1'b1;
                    end else if (found) begin
                        n_present = 1'b1;
                        n_run = found_idx;
                        n_slice = found_reload;
                        n_reload = 1'b1;
                    end else if (r_present) begin
                        n_present = 1'b0;
                        n_run = '0;
                    end
                end
                rrss_pkg::FUNC_CREATE: begin
                    if (!empty_hit[SW]) begin
                        n_status = rrss_pkg::STATUS_FULL;
                    end else begin
                        n_user[empty_idx] = i_item.is_user;
                        n_stat[empty_idx] = rrss_pkg::ST_READY;
                        n_save[empty_idx] = rrss_pkg::ST_NONE;
                        new_wide = {4'b0, empty_idx};
                        n_new_id = new_wide[3:0];
                        if (!r_present) begin
                            n_present = 1'b1;
                            n_run = empty_idx;
                            n_slice = create_reload;
                            n_reload = 1'b1;
                        end
                    end
                end
                rrss_pkg::FUNC_BLOCK: begin
                    if (bad_id) begin
                        n_status = rrss_pkg::STATUS_BAD_ID;
                    end else begin
                        n_stat[id_slot] = rrss_pkg::ST_PENDING;
                        if (found) begin
                            n_present = 1'b1;
                            n_run = found_idx;
                            n_slice = found_reload;
                            n_reload = 1'b1;
                        end else begin
                            n_present = 1'b0;
                            n_run = '0;
                        end
                    end
                end
                rrss_pkg::FUNC_UNBLOCK: begin
                    if (bad_id) begin
                        n_status = rrss_pkg::STATUS_BAD_ID;
                    end else begin
                        n_stat[id_slot] = rrss_pkg::ST_READY;
                    end
                end
                rrss_pkg::FUNC_ENTER: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!empty_v[i] && !(r_present && r_run == SW'(i))) begin
                            n_save[i] = r_stat[i];
                            n_stat[i] = rrss_pkg::ST_PENDING;
                        end
                    end
                end
                rrss_pkg::FUNC_EXIT: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!empty_v[i] && !(r_present && r_run == SW'(i))) begin
                            if (r_save[i] != rrss_pkg::ST_NONE) begin
                                n_stat[i] = r_save[i];
                            end
                            n_save[i] = rrss_pkg::ST_NONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign run_wide = {4'b0, n_run};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_stat[i] <= rrss_pkg::ST_EMPTY;
                r_save[i] <= rrss_pkg::ST_NONE;
            end
            r_user <= '0;
            r_run <= '0;
            r_present <= 1'b0;
            r_slice <= '0;
            r_kernel <= rrss_pkg::KERNEL_SLICE_RESET;
            r_usr_slice <= rrss_pkg::USER_SLICE_RESET;
            r_done <= 1'b0;
        end else begin
            r_stat <= n_stat;
            r_save <= n_save;
            r_user <= n_user;
            r_run <= n_run;
            r_present <= n_present;
            r_slice <= n_slice;
            r_done <= i_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rrss_pkg::CFG_KERNEL_SLICE: r_kernel <= i_cfg_data;
                    rrss_pkg::CFG_USER_SLICE: r_usr_slice <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_status <= n_status;
            r_new_id <= n_new_id;
            r_out_run <= n_present ? run_wide[3:0] : '0;
            r_out_valid <= n_present;
            r_reload <= n_reload;
        end
    end

    assign o_pop = i_valid;
    assign o_done = r_done;
    assign o_status_code = r_status;
    assign o_new_id = r_new_id;
    assign o_running_id = r_out_run;
    assign o_running_valid = r_out_valid;
    assign o_context_reload = r_reload;

    `RRSS_ASSERT_NOW(a_idle_slot_zero, !r_present, r_run == '0)
    `RRSS_ASSERT_NEXT(a_pop_gives_result, i_valid, o_done)
    `RRSS_ASSERT_NOW(a_reload_has_runner, o_done && o_context_reload, o_running_valid)
    `RRSS_ASSERT_NOW(a_runner_not_empty, r_present, !empty_v[r_run])

endmodule
